/* src/efb_pkg.sv */
// Shared types, constants and the CRC-32 byte step for the Ethernet frame builder.
// No dependencies; every other file imports this package.
package efb_pkg;

  localparam int unsigned MAX_PAYLOAD = 1500;
  localparam int unsigned MIN_PAYLOAD = 46;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned HDR_BYTES   = 14;
  localparam int unsigned FCS_BYTES   = 4;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 64;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [IDX_W-1:0] HDR_LAST_IDX = IDX_W'(HDR_BYTES - 1);
  localparam logic [IDX_W-1:0] FCS_LAST_IDX = IDX_W'(FCS_BYTES - 1);

  // Register index, taken from paddr[3] (8-byte register slots)
  localparam logic CFG_SOURCE_MAC = 1'b0;

  typedef struct packed {
    logic [MAC_W-1:0] dest_mac;
    logic [15:0]      eth_type;
    logic [7:0]       payload_byte;
    logic             last_byte;
  } efb_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       too_long;
  } efb_out_t;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_HDR,
    ST_PAY,
    ST_PAD,
    ST_FCS
  } efb_state_t;

  typedef enum logic [2:0] {
    SRC_HDR,
    SRC_IN,
    SRC_HOLD,
    SRC_ZERO,
    SRC_FCS
  } efb_src_t;

  typedef struct packed {
    logic     load;
    logic     set_in_frame;
    logic     emit;
    efb_src_t src;
    logic     crc_upd;
    logic     count_inc;
    logic     set_ovf;
    logic     idx_clr;
    logic     idx_inc;
    logic     fin;
    logic     clear_frame;
  } efb_cmd_t;

  typedef struct packed {
    logic in_frame;
    logic out_free;
    logic count_lt_max;
    logic cnt_next_lt_min;
    logic idx_hdr_last;
    logic idx_fcs_last;
    logic held_last;
    logic in_last;
  } efb_status_t;

  // Reflected CRC-32, one byte (eight bit steps)
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'b0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* src/efb_datapath.sv */
// Datapath of the frame builder: config register, item hold, frame counters,
// CRC register and the output register. Uses efb_pkg; driven by efb_ctrl.
module efb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  efb_pkg::efb_in_t              in_item,
  output efb_pkg::efb_out_t             out_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [efb_pkg::PADDR_W-1:0]   paddr,
  input  logic [efb_pkg::PDATA_W-1:0]   pwdata,
  output logic [efb_pkg::PDATA_W-1:0]   prdata,
  input  efb_pkg::efb_cmd_t             cmd,
  output efb_pkg::efb_status_t          status
);
  import efb_pkg::*;

  logic [MAC_W-1:0]   source_mac;
  efb_in_t            held;
  logic               in_frame;
  logic [COUNT_W-1:0] count;
  logic [31:0]        crc;
  logic               ovf;
  logic [IDX_W-1:0]   idx;
  logic [COUNT_W:0]   count_plus;
  logic [7:0]         hdr_bytes [HDR_BYTES];
  logic [31:0]        fcs;
  logic [7:0]         byte_sel;
  logic               out_free;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      source_mac <= '0;
    end else if (psel && penable && pwrite && paddr[3] == CFG_SOURCE_MAC) begin
      source_mac <= pwdata[MAC_W-1:0];
    end
  end

  assign prdata = (paddr[3] == CFG_SOURCE_MAC) ? PDATA_W'(source_mac) : '0;

  // Header bytes in wire order
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      hdr_bytes[i]     = held.dest_mac[8*(5-i) +: 8];
      hdr_bytes[6 + i] = source_mac[8*(5-i) +: 8];
    end
    hdr_bytes[12] = held.eth_type[15:8];
    hdr_bytes[13] = held.eth_type[7:0];
  end

  assign fcs = ~crc;

  always_comb begin
    unique case (cmd.src)
      SRC_HDR:  byte_sel = hdr_bytes[idx];
      SRC_IN:   byte_sel = in_item.payload_byte;
      SRC_HOLD: byte_sel = held.payload_byte;
      SRC_ZERO: byte_sel = 8'h00;
      SRC_FCS:  byte_sel = fcs[8*idx[1:0] +: 8];
      default:  byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held <= in_item;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_frame) begin
      in_frame <= 1'b0;
      count    <= '0;
      crc      <= CRC_INIT;
      ovf      <= 1'b0;
    end else begin
      if (cmd.set_in_frame) in_frame <= 1'b1;
      if (cmd.count_inc)    count    <= count_plus[COUNT_W-1:0];
      if (cmd.crc_upd)      crc      <= crc_byte(crc, byte_sel);
      if (cmd.set_ovf)      ovf      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // Output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.frame_byte <= byte_sel;
      out_item.frame_end  <= cmd.fin;
      out_item.too_long   <= cmd.fin && ovf;
    end
  end

  assign count_plus = {1'b0, count} + 1'b1;

  assign status.in_frame        = in_frame;
  assign status.out_free        = out_free;
  assign status.count_lt_max    = count < COUNT_W'(MAX_PAYLOAD);
  assign status.cnt_next_lt_min = count_plus < (COUNT_W+1)'(MIN_PAYLOAD);
  assign status.idx_hdr_last    = idx == HDR_LAST_IDX;
  assign status.idx_fcs_last    = idx == FCS_LAST_IDX;
  assign status.held_last       = held.last_byte;
  assign status.in_last         = in_item.last_byte;

  a_fin_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.fin |-> in_frame)
    else $error("frame end emitted outside a frame");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_PAYLOAD))
    else $error("payload count above maximum");

  a_too_long_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.too_long |-> out_item.frame_end)
    else $error("too_long flagged away from frame end");

  a_crc_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_frame |=> crc == CRC_INIT && !in_frame)
    else $error("frame state not cleared after FCS");

endmodule

/* src/efb_ctrl.sv */
// Controller state machine of the frame builder: sequences header, payload,
// pad and FCS bytes. Uses efb_pkg; drives efb_datapath via command struct.
module efb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  efb_pkg::efb_status_t status,
  output efb_pkg::efb_cmd_t    cmd
);
  import efb_pkg::*;

  efb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_WAIT: begin
        if (in_valid && status.out_free) begin
          priority if (!status.in_frame) begin
            state_next = ST_HDR;
          end else if (status.in_last) begin
            state_next = (status.count_lt_max && status.cnt_next_lt_min) ? ST_PAD : ST_FCS;
          end else begin
            state_next = ST_WAIT;
          end
        end
      end
      ST_HDR: begin
        if (status.out_free && status.idx_hdr_last) state_next = ST_PAY;
      end
      ST_PAY: begin
        if (status.out_free) begin
          if (status.held_last) begin
            state_next = status.cnt_next_lt_min ? ST_PAD : ST_FCS;
          end else begin
            state_next = ST_WAIT;
          end
        end
      end
      ST_PAD: begin
        if (status.out_free && !status.cnt_next_lt_min) state_next = ST_FCS;
      end
      ST_FCS: begin
        if (status.out_free && status.idx_fcs_last) state_next = ST_WAIT;
      end
      default: state_next = ST_WAIT;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_WAIT: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          priority if (!status.in_frame) begin
            cmd.load         = 1'b1;
            cmd.set_in_frame = 1'b1;
            cmd.idx_clr      = 1'b1;
          end else if (status.count_lt_max) begin
            cmd.emit      = 1'b1;
            cmd.src       = SRC_IN;
            cmd.crc_upd   = 1'b1;
            cmd.count_inc = 1'b1;
            cmd.idx_clr   = 1'b1;
          end else begin
            cmd.set_ovf = 1'b1;
            cmd.idx_clr = 1'b1;
          end
        end
      end
      ST_HDR: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.src     = SRC_HDR;
          cmd.crc_upd = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      ST_PAY: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = SRC_HOLD;
          cmd.crc_upd   = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.idx_clr   = 1'b1;
        end
      end
      ST_PAD: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = SRC_ZERO;
          cmd.crc_upd   = 1'b1;
          cmd.count_inc = 1'b1;
        end
      end
      ST_FCS: begin
        if (status.out_free) begin
          cmd.emit        = 1'b1;
          cmd.src         = SRC_FCS;
          cmd.idx_inc     = 1'b1;
          cmd.fin         = status.idx_fcs_last;
          cmd.clear_frame = status.idx_fcs_last;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_ready_only_waiting: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_WAIT && status.out_free)
    else $error("input taken outside the wait state");

  a_hdr_to_pay: assert property (@(posedge clk) disable iff (rst)
    state == ST_HDR && status.out_free && status.idx_hdr_last |=> state == ST_PAY)
    else $error("header did not hand over to payload");

  a_fcs_ends_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> state == ST_FCS && cmd.emit)
    else $error("frame end outside the FCS state");

endmodule

/* src/ethernet_frame_builder.sv */
// Top level of the Ethernet frame builder: header, zero pad and CRC-32 FCS.
// Uses efb_pkg; instantiates efb_ctrl and efb_datapath.
//
//   channel   dir  handshake            payload
//   in        in   in_valid / in_stall   in_item  (efb_in_t: dest_mac, eth_type,
//                                                  payload_byte, last_byte)
//   out       out  out_valid / out_stall out_item (efb_out_t: frame_byte,
//                                                  frame_end, too_long)
//   cfg       in   APB psel/penable      paddr[3:0], pwdata/prdata 64 b, pready = 1
//
// Rate: at most one output byte per cycle while out_stall is low, set by the single
//   output register. A mid-frame payload item is loaded into the output register as
//   it is accepted. The first item of a frame is accepted, then 14 header bytes and
//   its payload byte are sent; an item marked last adds zero pad up to 46 payload
//   bytes when short, then 4 FCS bytes. Payload bytes past 1500 produce nothing.
// Reset: rst synchronous, active high; clears frame state, source_mac and out_valid.
// Stalls: out_stall holds the output register; the sequencer waits, and the
//   input is stalled whenever the output register cannot take a byte and
//   while header, held payload, pad or FCS bytes are being sent.
module ethernet_frame_builder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  efb_pkg::efb_in_t              in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output efb_pkg::efb_out_t             out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [efb_pkg::PADDR_W-1:0]   paddr,
  input  logic [efb_pkg::PDATA_W-1:0]   pwdata,
  output logic [efb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import efb_pkg::*;

  efb_cmd_t    cmd;
  efb_status_t status;
  logic        in_ready;

  // Config writes complete in the access phase; no wait states
  assign pready   = 1'b1;
  assign in_stall = !in_ready;

  efb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  efb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
